// ===== rtl/q24_8_fixed_point_alu_core_macros.svh =====
// assertion macros for the fixed-point unit
`ifndef Q24_8_FIXED_POINT_ALU_CORE_MACROS_SVH
`define Q24_8_FIXED_POINT_ALU_CORE_MACROS_SVH

// property that must hold in the same cycle
`define Q24_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// property whose consequent is checked in the cycle after the antecedent
`define Q24_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) ante |=> cons) else $error(msg);

`endif

// ===== rtl/q24alu_pkg.sv =====
// shared types and operation codes of the fixed-point unit
package q24alu_pkg;

  localparam int DATA_W = 32;
  localparam int OP_W   = 5;
  localparam int SIG_W  = 24;

  typedef enum logic [OP_W-1:0] {
    OP_ADD        = 5'd0,
    OP_SUB        = 5'd1,
    OP_MUL        = 5'd2,
    OP_DIV        = 5'd3,
    OP_LT         = 5'd4,
    OP_LE         = 5'd5,
    OP_GT         = 5'd6,
    OP_GE         = 5'd7,
    OP_EQ         = 5'd8,
    OP_NE         = 5'd9,
    OP_MIN        = 5'd10,
    OP_MAX        = 5'd11,
    OP_INC        = 5'd12,
    OP_FROM_INT   = 5'd13,
    OP_FROM_FLOAT = 5'd14,
    OP_TO_INT     = 5'd15,
    OP_TO_FLOAT   = 5'd16
  } op_e;

  typedef struct packed {
    logic            vld;
    logic [OP_W-1:0] op;
    logic            cmp;
    logic            err;
    logic            neg;
  } ctl_t;

endpackage

// ===== rtl/q24alu_req_if.sv =====
// request channel: operation and two operands
interface q24alu_req_if;
  logic        valid;
  logic        ready;
  logic [4:0]  operation;
  logic signed [31:0] operand_a;
  logic signed [31:0] operand_b;

  modport source (output valid, output operation, output operand_a, output operand_b,
                  input ready);
  modport sink (input valid, input operation, input operand_a, input operand_b,
                output ready);
endinterface

// ===== rtl/q24alu_rsp_if.sv =====
// response channel: result word and flags
interface q24alu_rsp_if;
  logic        valid;
  logic        ready;
  logic signed [31:0] result_value;
  logic        compare_true;
  logic        error_flag;

  modport source (output valid, output result_value, output compare_true,
                  output error_flag, input ready);
  modport sink (input valid, input result_value, input compare_true, input error_flag,
                output ready);
endinterface

// ===== rtl/q24alu_front.sv =====
// first compute stage: simple ops, product, float decode and chain setup
module q24alu_front #(
  parameter int FRACTION_BITS = 8,
  parameter int DW = 40,
  parameter int CW = 6
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 vld_i,
  input  logic [4:0]           op_i,
  input  logic signed [31:0]   a_i,
  input  logic signed [31:0]   b_i,
  output q24alu_pkg::ctl_t     ctl_o,
  output logic [31:0]          res_o,
  output logic signed [63:0]   prod_o,
  output logic [DW-1:0]        dvd_o,
  output logic [31:0]          rem_o,
  output logic [31:0]          dvs_o,
  output logic [CW-1:0]        cnt_o
);
  import q24alu_pkg::*;

  ctl_t               ctl_d, ctl_q;
  logic [31:0]        res_d, res_q;
  logic signed [63:0] prod_q;
  logic [DW-1:0]      dvd_d, dvd_q;
  logic [31:0]        dvs_d, dvs_q;
  logic [31:0]        abs_a, abs_b;
  logic [31:0]        f2x_res;
  logic               f2x_err;

  assign abs_a = a_i[31] ? 32'(-a_i) : 32'(a_i);
  assign abs_b = b_i[31] ? 32'(-b_i) : 32'(b_i);

  always_comb begin
    logic [7:0]  e;
    logic [22:0] mg;
    logic [23:0] sig;
    logic [63:0] sigw;
    logic [63:0] rsh;
    logic [63:0] magw;
    logic [63:0] limit;
    logic        ovf;
    logic [5:0]  shamt;
    logic [4:0]  kk;
    int          sh;
    int          k;
    e      = a_i[30:23];
    mg     = a_i[22:0];
    sig    = {1'b1, mg};
    sigw   = {40'b0, sig};
    rsh    = '0;
    limit  = a_i[31] ? 64'h8000_0000 : 64'h7FFF_FFFF;
    ovf    = 1'b0;
    magw   = '0;
    shamt  = '0;
    kk     = '0;
    sh     = int'(e) - 150 + FRACTION_BITS;
    k      = -sh;
    f2x_err = 1'b0;
    f2x_res = '0;
    if (e == 8'hFF) begin
      f2x_err = 1'b1;
      f2x_res = (mg != '0) ? 32'h0 : limit[31:0];
    end else if (e != 8'h00) begin
      if (sh >= 40) begin
        ovf = 1'b1;
      end else if (sh >= 0) begin
        shamt = sh[5:0];
        magw  = sigw << shamt;
      end else if (k <= 25) begin
        kk   = k[4:0];
        rsh  = sigw >> (kk - 5'd1);
        magw = (sigw >> kk) + {63'b0, rsh[0]};
      end
      if (ovf || magw > limit) begin
        f2x_err = 1'b1;
        f2x_res = limit[31:0];
      end else begin
        f2x_res = a_i[31] ? 32'(-magw[31:0]) : magw[31:0];
      end
    end
  end

  always_comb begin
    ctl_d     = '0;
    ctl_d.vld = vld_i;
    ctl_d.op  = op_i;
    res_d     = '0;
    dvd_d     = '0;
    dvs_d     = '0;
    case (op_i)
      OP_ADD:        res_d = 32'(a_i + b_i);
      OP_SUB:        res_d = 32'(a_i - b_i);
      OP_MUL:        res_d = '0;
      OP_DIV: begin
        dvd_d     = {abs_a, {FRACTION_BITS{1'b0}}};
        dvs_d     = abs_b;
        ctl_d.neg = a_i[31] ^ b_i[31];
        ctl_d.err = (b_i == '0);
      end
      OP_LT:         ctl_d.cmp = (a_i <  b_i);
      OP_LE:         ctl_d.cmp = (a_i <= b_i);
      OP_GT:         ctl_d.cmp = (a_i >  b_i);
      OP_GE:         ctl_d.cmp = (a_i >= b_i);
      OP_EQ:         ctl_d.cmp = (a_i == b_i);
      OP_NE:         ctl_d.cmp = (a_i != b_i);
      OP_MIN:        res_d = (a_i < b_i) ? a_i : b_i;
      OP_MAX:        res_d = (a_i < b_i) ? b_i : a_i;
      OP_INC:        res_d = 32'(a_i + 32'sd1);
      OP_FROM_INT:   res_d = 32'(a_i <<< FRACTION_BITS);
      OP_FROM_FLOAT: begin
        res_d     = f2x_res;
        ctl_d.err = f2x_err;
      end
      OP_TO_INT:     res_d = 32'(a_i >>> FRACTION_BITS);
      OP_TO_FLOAT: begin
        dvd_d     = {{FRACTION_BITS{1'b0}}, abs_a};
        ctl_d.neg = a_i[31];
      end
      default:       ctl_d.op = op_i;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else if (en_i) begin
      ctl_q <= ctl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      res_q  <= res_d;
      prod_q <= 64'(a_i) * 64'(b_i);
      dvd_q  <= dvd_d;
      dvs_q  <= dvs_d;
    end
  end

  assign ctl_o  = ctl_q;
  assign res_o  = res_q;
  assign prod_o = prod_q;
  assign dvd_o  = dvd_q;
  assign rem_o  = '0;
  assign dvs_o  = dvs_q;
  assign cnt_o  = '0;

endmodule

// ===== rtl/q24alu_cell.sv =====
// chain cell: one quotient bit or one normalize step per cycle while en_i is high
module q24alu_cell #(
  parameter int DW = 40,
  parameter int CW = 6
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  q24alu_pkg::ctl_t     ctl_i,
  input  logic [31:0]          res_i,
  input  logic signed [63:0]   prod_i,
  input  logic [DW-1:0]        dvd_i,
  input  logic [31:0]          rem_i,
  input  logic [31:0]          dvs_i,
  input  logic [CW-1:0]        cnt_i,
  output q24alu_pkg::ctl_t     ctl_o,
  output logic [31:0]          res_o,
  output logic signed [63:0]   prod_o,
  output logic [DW-1:0]        dvd_o,
  output logic [31:0]          rem_o,
  output logic [31:0]          dvs_o,
  output logic [CW-1:0]        cnt_o
);
  import q24alu_pkg::*;

  ctl_t               ctl_q;
  logic [31:0]        res_q, rem_d, rem_q, dvs_q;
  logic signed [63:0] prod_q;
  logic [DW-1:0]      dvd_d, dvd_q;
  logic [CW-1:0]      cnt_d, cnt_q;
  logic [32:0]        trial, diff;
  logic               ge;

  assign trial = {rem_i, dvd_i[DW-1]};
  assign ge    = (trial >= {1'b0, dvs_i});
  assign diff  = trial - {1'b0, dvs_i};

  always_comb begin
    rem_d = rem_i;
    dvd_d = dvd_i;
    cnt_d = cnt_i;
    if (ctl_i.op == OP_DIV) begin
      rem_d = ge ? diff[31:0] : trial[31:0];
      dvd_d = {dvd_i[DW-2:0], ge};
    end else if (ctl_i.op == OP_TO_FLOAT) begin
      if (!dvd_i[DW-1] && dvd_i != '0) begin
        dvd_d = {dvd_i[DW-2:0], 1'b0};
        cnt_d = cnt_i + CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else if (en_i) begin
      ctl_q <= ctl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      res_q  <= res_i;
      prod_q <= prod_i;
      dvd_q  <= dvd_d;
      rem_q  <= rem_d;
      dvs_q  <= dvs_i;
      cnt_q  <= cnt_d;
    end
  end

  assign ctl_o  = ctl_q;
  assign res_o  = res_q;
  assign prod_o = prod_q;
  assign dvd_o  = dvd_q;
  assign rem_o  = rem_q;
  assign dvs_o  = dvs_q;
  assign cnt_o  = cnt_q;

endmodule

// ===== rtl/q24alu_back.sv =====
// last stage: product scaling, quotient sign, float packing, output register
module q24alu_back #(
  parameter int FRACTION_BITS = 8,
  parameter int DW = 40,
  parameter int CW = 6
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  q24alu_pkg::ctl_t     ctl_i,
  input  logic [31:0]          res_i,
  input  logic signed [63:0]   prod_i,
  input  logic [DW-1:0]        dvd_i,
  input  logic [CW-1:0]        cnt_i,
  output logic                 vld_o,
  output logic signed [31:0]   res_o,
  output logic                 cmp_o,
  output logic                 err_o
);
  import q24alu_pkg::*;

  localparam logic [63:0] ROUND_BIAS = 64'((64'd1 << FRACTION_BITS) - 64'd1);

  logic               vld_q;
  logic [31:0]        res_d, res_q;
  logic               cmp_q, err_q;
  logic signed [63:0] prod_adj;
  logic [31:0]        quo;
  logic [23:0]        sig;
  logic [24:0]        sig_sum;
  logic               rnd;
  logic [7:0]         ex;
  logic [31:0]        flt;

  assign prod_adj = prod_i + (prod_i[63] ? $signed(ROUND_BIAS) : 64'sd0);
  assign quo      = ctl_i.neg ? 32'(-dvd_i[31:0]) : dvd_i[31:0];

  assign sig     = dvd_i[DW-1 -: SIG_W];
  assign rnd     = dvd_i[DW-SIG_W-1] & ((|dvd_i[DW-SIG_W-2:0]) | dvd_i[DW-SIG_W]);
  assign sig_sum = {1'b0, sig} + {24'b0, rnd};
  assign ex      = 8'(DW + 126 - FRACTION_BITS - int'(cnt_i) + int'(sig_sum[24]));
  assign flt     = (dvd_i == '0) ? 32'h0 :
                   {ctl_i.neg, ex, (sig_sum[24] ? sig_sum[23:1] : sig_sum[22:0])};

  always_comb begin
    res_d = res_i;
    case (ctl_i.op)
      OP_MUL:      res_d = prod_adj[FRACTION_BITS+31:FRACTION_BITS];
      OP_DIV:      res_d = ctl_i.err ? 32'h0 : quo;
      OP_TO_FLOAT: res_d = flt;
      default:     res_d = res_i;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= ctl_i.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      res_q <= res_d;
      cmp_q <= ctl_i.cmp;
      err_q <= ctl_i.err;
    end
  end

  assign vld_o = vld_q;
  assign res_o = res_q;
  assign cmp_o = cmp_q;
  assign err_o = err_q;

endmodule

// ===== rtl/q24_8_fixed_point_alu_core.sv =====
// Signed fixed-point unit with FRACTION_BITS fraction bits in a 32-bit word. One item is
// taken every cycle unless the output stalls, and each gives one result, in order, after
// passing an input register, a decode stage, a row of 32 + FRACTION_BITS cells that
// each form one quotient bit (divide) or one normalize shift (fixed to float), and the
// output register. The length of that cell row sets the latency; a stalled output holds
// the whole pipe and lowers ready in the same cycle.
`include "q24_8_fixed_point_alu_core_macros.svh"

module q24_8_fixed_point_alu_core #(
  parameter int FRACTION_BITS = 8
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  q24alu_req_if.sink     req_i,
  q24alu_rsp_if.source   rsp_o
);
  import q24alu_pkg::*;

  localparam int DW = DATA_W + FRACTION_BITS;
  localparam int CW = $clog2(DW + 1);

  logic               en;
  logic               vld0_q;
  logic [4:0]         op0_q;
  logic signed [31:0] a0_q, b0_q;

  ctl_t               ctl_s  [0:DW];
  logic [31:0]        res_s  [0:DW];
  logic signed [63:0] prod_s [0:DW];
  logic [DW-1:0]      dvd_s  [0:DW];
  logic [31:0]        rem_s  [0:DW];
  logic [31:0]        dvs_s  [0:DW];
  logic [CW-1:0]      cnt_s  [0:DW];

  assign en          = !rsp_o.valid || rsp_o.ready;
  assign req_i.ready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld0_q <= 1'b0;
    end else if (en) begin
      vld0_q <= req_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      op0_q <= req_i.operation;
      a0_q  <= req_i.operand_a;
      b0_q  <= req_i.operand_b;
    end
  end

  q24alu_front #(.FRACTION_BITS(FRACTION_BITS), .DW(DW), .CW(CW)) u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (vld0_q),
    .op_i   (op0_q),
    .a_i    (a0_q),
    .b_i    (b0_q),
    .ctl_o  (ctl_s[0]),
    .res_o  (res_s[0]),
    .prod_o (prod_s[0]),
    .dvd_o  (dvd_s[0]),
    .rem_o  (rem_s[0]),
    .dvs_o  (dvs_s[0]),
    .cnt_o  (cnt_s[0])
  );

  for (genvar i = 0; i < DW; i++) begin : g_cell
    q24alu_cell #(.DW(DW), .CW(CW)) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .ctl_i  (ctl_s[i]),
      .res_i  (res_s[i]),
      .prod_i (prod_s[i]),
      .dvd_i  (dvd_s[i]),
      .rem_i  (rem_s[i]),
      .dvs_i  (dvs_s[i]),
      .cnt_i  (cnt_s[i]),
      .ctl_o  (ctl_s[i+1]),
      .res_o  (res_s[i+1]),
      .prod_o (prod_s[i+1]),
      .dvd_o  (dvd_s[i+1]),
      .rem_o  (rem_s[i+1]),
      .dvs_o  (dvs_s[i+1]),
      .cnt_o  (cnt_s[i+1])
    );
  end

  q24alu_back #(.FRACTION_BITS(FRACTION_BITS), .DW(DW), .CW(CW)) u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .ctl_i  (ctl_s[DW]),
    .res_i  (res_s[DW]),
    .prod_i (prod_s[DW]),
    .dvd_i  (dvd_s[DW]),
    .cnt_i  (cnt_s[DW]),
    .vld_o  (rsp_o.valid),
    .res_o  (rsp_o.result_value),
    .cmp_o  (rsp_o.compare_true),
    .err_o  (rsp_o.error_flag)
  );

  `Q24_ASSERT(a_cmp_zero, rsp_o.valid && rsp_o.compare_true |-> rsp_o.result_value == 32'sd0, "comparison with nonzero result")
  `Q24_ASSERT(a_cmp_err, rsp_o.valid |-> !(rsp_o.compare_true && rsp_o.error_flag), "comparison flagged as error")
  `Q24_ASSERT(a_rem_bound, ctl_s[DW].vld && ctl_s[DW].op == OP_DIV && dvs_s[DW] != 32'd0 |-> rem_s[DW] < dvs_s[DW], "divide remainder not below divisor")
  `Q24_ASSERT_NEXT(a_out_load, ctl_s[DW].vld && en, rsp_o.valid, "finished item not presented")

endmodule

// ===== test/testbench.sv =====
// self-checking testbench for the q24.8 fixed-point unit, with a predicting scoreboard
`timescale 1ns / 100ps

module testbench;
  import q24alu_pkg::*;

  typedef struct {
    logic [31:0] value;
    bit          cmp;
    bit          err;
  } alu_result_t;

  class alu_scoreboard;
    alu_result_t pending[$];
    int          errors = 0;

    function automatic logic [31:0] float_to_q(logic [31:0] bits, output bit err);
      bit                    neg;
      logic [7:0]            e;
      logic [22:0]           m;
      longint unsigned       sig, mag, limit;
      int                    sh, k;
      neg   = bits[31];
      e     = bits[30:23];
      m     = bits[22:0];
      limit = neg ? 64'h8000_0000 : 64'h7FFF_FFFF;
      err   = 0;
      if (e == 8'hFF) begin
        err = 1;
        if (m != 0) return 32'h0;
        return neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
      end
      if (e == 0) return 32'h0;
      sig = {40'd0, 1'b1, m};
      sh  = int'(e) - 150 + 8;
      if (sh >= 40) mag = limit + 1;
      else if (sh >= 0) mag = sig << sh;
      else begin
        k = -sh;
        if (k > 25) mag = 0;
        else mag = (sig >> k) + ((sig >> (k - 1)) & 64'd1);
      end
      if (mag > limit) begin
        err = 1;
        return neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
      end
      if (neg) return 32'(64'h1_0000_0000 - mag);
      return mag[31:0];
    endfunction

    function automatic logic [31:0] q_to_float(longint a);
      bit              sign;
      longint unsigned mag, sig, rem, half;
      int              p, k, ex;
      sign = a < 0;
      mag  = a < 0 ? -a : a;
      p    = 0;
      if (mag == 0) return 32'h0;
      while (p < 40 && (mag >> (p + 1)) != 0) p++;
      if (p <= 23) sig = mag << (23 - p);
      else begin
        k    = p - 23;
        rem  = mag & ((64'd1 << k) - 1);
        half = 64'd1 << (k - 1);
        sig  = mag >> k;
        if (rem > half || (rem == half && sig[0])) sig++;
        if (sig == (64'd1 << 24)) begin
          sig >>= 1;
          p++;
        end
      end
      ex = p - 8 + 127;
      return {sign, ex[7:0], sig[22:0]};
    endfunction

    function automatic alu_result_t compute(logic [4:0] op, logic [31:0] a_raw,
                                            logic [31:0] b_raw);
      alu_result_t r;
      longint      a, b, t;
      bit          e;
      a = longint'($signed(a_raw));
      b = longint'($signed(b_raw));
      r = '{32'h0, 0, 0};
      case (op)
        OP_ADD:        r.value = 32'(a + b);
        OP_SUB:        r.value = 32'(a - b);
        OP_MUL: begin
          t = (a * b) / 256;
          r.value = t[31:0];
        end
        OP_DIV: begin
          if (b == 0) r.err = 1;
          else begin
            t = (a * 256) / b;
            r.value = t[31:0];
          end
        end
        OP_LT:         r.cmp = a < b;
        OP_LE:         r.cmp = a <= b;
        OP_GT:         r.cmp = a > b;
        OP_GE:         r.cmp = a >= b;
        OP_EQ:         r.cmp = a == b;
        OP_NE:         r.cmp = a != b;
        OP_MIN:        r.value = a < b ? a_raw : b_raw;
        OP_MAX:        r.value = a < b ? b_raw : a_raw;
        OP_INC:        r.value = a_raw + 32'd1;
        OP_FROM_INT:   r.value = a_raw << 8;
        OP_FROM_FLOAT: begin
          r.value = float_to_q(a_raw, e);
          r.err = e;
        end
        OP_TO_INT:     r.value = $signed(a_raw) >>> 8;
        OP_TO_FLOAT:   r.value = q_to_float(a);
        default: ;
      endcase
      return r;
    endfunction

    function void note_transfer(logic [4:0] op, logic [31:0] a, logic [31:0] b);
      pending.push_back(compute(op, a, b));
    endfunction

    function void check_result(logic [31:0] value, logic cmp, logic err);
      alu_result_t x;
      if (pending.size() == 0) begin
        $error("result with nothing pending: value %h", value);
        errors++;
        return;
      end
      x = pending.pop_front();
      if (value !== x.value) begin
        $error("result_value: expected %h, got %h", x.value, value);
        errors++;
      end
      if (cmp !== x.cmp) begin
        $error("compare_true: expected %0d, got %0d", x.cmp, cmp);
        errors++;
      end
      if (err !== x.err) begin
        $error("error_flag: expected %0d, got %0d", x.err, err);
        errors++;
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  q24alu_req_if req ();
  q24alu_rsp_if rsp ();
  alu_scoreboard scoreboard = new();
  int  sent_count = 0;
  bit  sender_quiet = 0;

  q24_8_fixed_point_alu_core uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req),
    .rsp_o  (rsp)
  );

  initial begin
    clk_i = 0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #20_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // receiver: random stalls, one long hold-off, one stretch always ready
  initial begin
    int cyc;
    rsp.ready = 0;
    cyc = 0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      cyc++;
      if (cyc >= 800 && cyc < 1000) rsp.ready <= 0;
      else if (cyc >= 1200 && cyc < 1500) rsp.ready <= 1;
      else rsp.ready <= ($urandom_range(99) >= 7);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && rsp.valid && rsp.ready)
      scoreboard.check_result(rsp.result_value, rsp.compare_true, rsp.error_flag);
  end

  task automatic send_item(logic [4:0] op, logic [31:0] a, logic [31:0] b);
    while (!sender_quiet && $urandom_range(99) < 7) begin
      @(negedge clk_i);
      req.valid <= 0;
      @(posedge clk_i);
    end
    @(negedge clk_i);
    req.valid     <= 1;
    req.operation <= op;
    req.operand_a <= a;
    req.operand_b <= b;
    do @(posedge clk_i); while (!req.ready);
    scoreboard.note_transfer(op, a, b);
    sent_count++;
  endtask

  function automatic logic [31:0] pick_operand();
    case ($urandom_range(9))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return 32'(int'($urandom_range(8)) - 4);
      3, 4:    return 32'(int'($urandom_range(4096)) - 2048);
      5:       return 32'(int'($urandom_range(1 << 20)) - (1 << 19));
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [31:0] pick_float();
    logic [7:0] ex;
    case ($urandom_range(9))
      0:       ex = 8'hFF;
      1:       ex = 8'h00;
      2:       ex = 8'($urandom_range(255));
      default: ex = 8'($urandom_range(150, 108));
    endcase
    return {1'($urandom_range(1)), ex, 23'($urandom())};
  endfunction

  task automatic random_item();
    logic [4:0]  op;
    logic [31:0] a, b;
    op = ($urandom_range(99) < 5) ? 5'($urandom_range(31, 17)) : 5'($urandom_range(16));
    a  = pick_operand();
    b  = pick_operand();
    if (op == OP_FROM_FLOAT) a = pick_float();
    if (op == OP_DIV && $urandom_range(9) == 0) b = 0;
    if (op >= OP_LT && op <= OP_MAX && $urandom_range(3) == 0) b = a;
    send_item(op, a, b);
  endtask

  initial begin
    req.valid     = 0;
    req.operation = 0;
    req.operand_a = 0;
    req.operand_b = 0;
    rst_ni        = 0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1;

    // directed corners
    send_item(OP_ADD,        32'h7FFF_FFFF, 32'h0000_0001);
    send_item(OP_SUB,        32'h8000_0000, 32'h0000_0001);
    send_item(OP_MUL,        32'h8000_0000, 32'h8000_0000);
    send_item(OP_MUL,        32'hFFFF_FF80, 32'h0000_0001);
    send_item(OP_DIV,        32'h0000_0100, 32'h0000_0000);
    send_item(OP_DIV,        32'h8000_0000, 32'hFFFF_FFFF);
    send_item(OP_DIV,        32'hFFFF_FD00, 32'h0000_0200);
    send_item(OP_LT,         32'h8000_0000, 32'h7FFF_FFFF);
    send_item(OP_LE,         32'h0000_0005, 32'h0000_0005);
    send_item(OP_GT,         32'h7FFF_FFFF, 32'h8000_0000);
    send_item(OP_GE,         32'hFFFF_FFFF, 32'h0000_0000);
    send_item(OP_EQ,         32'h1234_5678, 32'h1234_5678);
    send_item(OP_NE,         32'h1234_5678, 32'h1234_5678);
    send_item(OP_MIN,        32'h8000_0000, 32'h7FFF_FFFF);
    send_item(OP_MAX,        32'h8000_0000, 32'h7FFF_FFFF);
    send_item(OP_INC,        32'h7FFF_FFFF, 32'h0000_0000);
    send_item(OP_FROM_INT,   32'hFF80_0001, 32'h0000_0000);
    send_item(OP_FROM_FLOAT, 32'h7FC0_0000, 32'h0);
    send_item(OP_FROM_FLOAT, 32'hFF80_0000, 32'h0);
    send_item(OP_FROM_FLOAT, 32'h8000_0001, 32'h0);
    send_item(OP_FROM_FLOAT, 32'hBB00_0000, 32'h0);
    send_item(OP_FROM_FLOAT, 32'h4B00_0000, 32'h0);
    send_item(OP_FROM_FLOAT, 32'hCB00_0000, 32'h0);
    send_item(OP_TO_INT,     32'hFFFF_FF01, 32'h0);
    send_item(OP_TO_FLOAT,   32'h8000_0000, 32'h0);
    send_item(OP_TO_FLOAT,   32'h7FFF_FFFF, 32'h0);
    send_item(5'd31,         32'hFFFF_FFFF, 32'hFFFF_FFFF);

    while (sent_count < 1600) begin
      sender_quiet = (sent_count >= 900 && sent_count < 1200);
      random_item();
    end
    @(negedge clk_i);
    req.valid <= 0;

    while (scoreboard.pending.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (scoreboard.pending.size() != 0) scoreboard.errors++;
    if (scoreboard.errors == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
